// File: rtl/lncrc_pkg.sv
package lncrc_pkg;

  localparam int unsigned CRC_W  = 16;
  localparam int unsigned BYTE_W = 8;

  localparam logic [CRC_W-1:0]  CRC_POLY        = 16'h1021;
  localparam logic [BYTE_W-1:0] HIGH_BYTE_START = 8'd128;
  localparam logic [BYTE_W-1:0] CH_QUESTION     = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_SPACE        = 8'h20;
  localparam logic [BYTE_W-1:0] CH_CR           = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_LF           = 8'h0A;

  // One input request after byte mapping.
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              line_last;
    logic              list_start;
  } item_t;

  // Bytes of 128 and above enter the CRC as a question mark.
  function automatic logic [BYTE_W-1:0] map_byte(input logic [BYTE_W-1:0] raw);
    map_byte = (raw >= HIGH_BYTE_START) ? CH_QUESTION : raw;
  endfunction

  // One byte through CRC-16/XMODEM, MSB first; flattens to an XOR network.
  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                input logic [BYTE_W-1:0] b);
    logic [CRC_W-1:0] c;
    c = crc ^ {b, {(CRC_W-BYTE_W){1'b0}}};
    for (int i = 0; i < BYTE_W; i++) begin
      if (c[CRC_W-1]) begin
        c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[CRC_W-2:0], 1'b0};
      end
    end
    crc_byte = c;
  endfunction

  // Appending CR LF is a fixed affine map of the CRC.
  function automatic logic [CRC_W-1:0] crc_crlf(input logic [CRC_W-1:0] crc);
    crc_crlf = crc_byte(crc_byte(crc, CH_CR), CH_LF);
  endfunction

endpackage

// File: rtl/lncrc_if.sv
interface lncrc_in_if;
  import lncrc_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              line_last;
  logic              list_start;

  modport source (output valid, data_byte, line_last, list_start, input ready);
  modport sink   (input valid, data_byte, line_last, list_start, output ready);
endinterface

interface lncrc_out_if;
  import lncrc_pkg::*;

  logic             valid;
  logic             ready;
  logic [CRC_W-1:0] list_crc;
  logic             crc_match;

  modport source (output valid, list_crc, crc_match, input ready);
  modport sink   (input valid, list_crc, crc_match, output ready);
endinterface

// File: rtl/lncrc_core.sv
module lncrc_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       advance,
  input  lncrc_pkg::item_t           item,
  output logic [lncrc_pkg::CRC_W-1:0] line_crc
);
  import lncrc_pkg::*;

  logic [CRC_W-1:0]  crc_through_all;
  logic [CRC_W-1:0]  crc_through_nonspace;
  logic [BYTE_W-1:0] held_byte;
  logic              held_valid;

  logic [CRC_W-1:0]  crc_through_all_next;
  logic [CRC_W-1:0]  crc_through_nonspace_next;
  logic [BYTE_W-1:0] held_byte_next;
  logic              held_valid_next;

  logic [CRC_W-1:0] all0, ns0, all1, ns1, all2, ns2;
  logic             hv0;
  logic             commit_held;
  logic             commit_cur;

  // Normalisation: commit the held byte, then the current one, then close the line.
  always_comb begin
    all0 = item.list_start ? '0 : crc_through_all;
    ns0  = item.list_start ? '0 : crc_through_nonspace;
    hv0  = item.list_start ? 1'b0 : held_valid;

    // A CR just before the final LF is dropped.
    commit_held = hv0 && !(item.line_last && item.data_byte == CH_LF && held_byte == CH_CR);
    all1 = commit_held ? crc_byte(all0, held_byte) : all0;
    ns1  = (commit_held && held_byte != CH_SPACE) ? all1 : ns0;

    // A final LF or CR never enters the CRC.
    commit_cur = item.data_byte != CH_LF && item.data_byte != CH_CR;
    all2 = commit_cur ? crc_byte(all1, item.data_byte) : all1;
    ns2  = (commit_cur && item.data_byte != CH_SPACE) ? all2 : ns1;

    line_crc = crc_crlf(ns2);

    if (item.line_last) begin
      crc_through_all_next      = line_crc;
      crc_through_nonspace_next = line_crc;
      held_byte_next            = '0;
      held_valid_next           = 1'b0;
    end else begin
      crc_through_all_next      = all1;
      crc_through_nonspace_next = ns1;
      held_byte_next            = item.data_byte;
      held_valid_next           = 1'b1;
    end
  end

  // Running CRCs and the one-byte holdback.
  always_ff @(posedge clk) begin
    if (rst) begin
      crc_through_all      <= '0;
      crc_through_nonspace <= '0;
      held_byte            <= '0;
      held_valid           <= 1'b0;
    end else if (advance) begin
      crc_through_all      <= crc_through_all_next;
      crc_through_nonspace <= crc_through_nonspace_next;
      held_byte            <= held_byte_next;
      held_valid           <= held_valid_next;
    end
  end

endmodule

// File: rtl/line_normalizing_crc16.sv
// The input register takes each accepted request; the result register loads from it as the
// request advances. Throughput: one byte per cycle, but a line end waits on a full result.
// The running CRC update is combinational.
// A result is produced only for a request that marks a line's last byte.
// Reset (rst, synchronous, active high) empties both registers, clears the line CRCs
// and the holdback, and sets the expected CRC to zero.
module line_normalizing_crc16 (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wr_en,
  input  logic [lncrc_pkg::CRC_W-1:0] cfg_wr_data,
  lncrc_in_if.sink                    item_in,
  lncrc_out_if.source                 result_out
);
  import lncrc_pkg::*;

  logic             expected_crc;
  logic [CRC_W-1:0] expected_crc_val;
  item_t            in_item;
  logic             in_vld;
  logic             out_vld;
  logic [CRC_W-1:0] out_crc;
  logic             out_match;
  logic [CRC_W-1:0] line_crc;
  logic             res_free;
  logic             advance;

  // A request moves on unless it would produce a result and the result register is full.
  assign res_free      = !out_vld || result_out.ready;
  assign advance       = in_vld && (!in_item.line_last || res_free);
  assign item_in.ready = !in_vld || advance;

  // Expected CRC register.
  always_ff @(posedge clk) begin
    if (rst) begin
      expected_crc_val <= '0;
    end else if (cfg_wr_en) begin
      expected_crc_val <= cfg_wr_data;
    end
  end

  assign expected_crc = (line_crc == expected_crc_val);

  // Input register, mapping high bytes on the way in.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item_in.valid && item_in.ready) begin
      in_vld <= 1'b1;
    end else if (advance) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_in.valid && item_in.ready) begin
      in_item.data_byte  <= map_byte(item_in.data_byte);
      in_item.line_last  <= item_in.line_last;
      in_item.list_start <= item_in.list_start;
    end
  end

  lncrc_core u_core (
    .clk      (clk),
    .rst      (rst),
    .advance  (advance),
    .item     (in_item),
    .line_crc (line_crc)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance && in_item.line_last) begin
      out_vld <= 1'b1;
    end else if (result_out.ready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_item.line_last) begin
      out_crc   <= line_crc;
      out_match <= expected_crc;
    end
  end

  assign result_out.valid     = out_vld;
  assign result_out.list_crc  = out_crc;
  assign result_out.crc_match = out_match;

endmodule
